// File: design/fec_pkg.sv
// fec_pkg: shared constants for the free extent claimer
// table depth, address width, word layout and status codes
// no dependencies
`timescale 1ns / 1ps

package fec_pkg;

  // table geometry
  localparam int MAX_EXTENTS = 16;
  localparam int ADDR_W      = 16;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

  // word layout on the stream ports
  localparam int IN_DATA_W   = 2 * ADDR_W;
  localparam int OUT_DATA_W  = 2 * ADDR_W;
  localparam int OUT_USER_W  = 3;

  // status codes carried on every result word
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OUTSIDE  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_ZERO_LEN = 2'd3;

  typedef logic [ADDR_W-1:0] addr_t;

endpackage

// File: design/free_extent_claimer.sv
// free_extent_claimer: address-ordered free extent table with claim and list-out
// one shared add/subtract unit under a small sequencer, table held in flip-flops
// depends on fec_pkg
`timescale 1ns / 1ps

// channel | direction | handshake             | payload
// --------+-----------+-----------------------+-----------------------------------------
// in_     | slave     | in_tvalid / in_tready | tdata: alloc_start, alloc_length
// out_    | master    | out_tvalid/out_tready | tdata: extent_start, extent_length;
//         |           |                       | tuser: list_empty, status; tlast: last
// cfg_    | slave     | cfg_valid / cfg_ready | cfg_data: memory_size
//
// a request walks the table one extent at a time (the walk is skipped for a zero length), then
// checks, trims, splits or removes the hit extent on the shared adder, then lists the result words
// the walk and every length sum go through the single add/subtract unit, one op a cycle
// in_tready is high only while the sequencer is idle; a finished word may still wait in
// the output register while the next request is taken
// reset leaves one free extent [0, 65535); a memory_size write leaves [0, memory_size), or none for zero
// a stalled out_tready simply holds the list-out; the table is not touched meanwhile

module free_extent_claimer (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fec_pkg::IN_DATA_W-1:0]    in_tdata,   // [15:0] alloc_start, [31:16] alloc_length
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fec_pkg::OUT_DATA_W-1:0]   out_tdata,  // [15:0] extent_start, [31:16] extent_length
  output logic [fec_pkg::OUT_USER_W-1:0]   out_tuser,  // [0] list_empty, [2:1] status
  output logic                             out_tlast,
  // configuration write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fec_pkg::ADDR_W-1:0]       cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_TAIL   = 3'd3;
  localparam logic [2:0] S_HEAD   = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  // what a claim does to the extent it lands in
  localparam logic [1:0] K_EXACT = 2'd0;
  localparam logic [1:0] K_FRONT = 2'd1;
  localparam logic [1:0] K_BACK  = 2'd2;
  localparam logic [1:0] K_SPLIT = 2'd3;

  localparam int AW = fec_pkg::ADDR_W;
  localparam int CW = fec_pkg::CNT_W;
  localparam int IW = fec_pkg::IDX_W;
  localparam int ME = fec_pkg::MAX_EXTENTS;

  // extent table
  fec_pkg::addr_t start_r [ME];
  fec_pkg::addr_t len_r   [ME];
  fec_pkg::addr_t start_nxt [ME];
  fec_pkg::addr_t len_nxt   [ME];
  logic [CW-1:0]  count_r, count_nxt;

  // sequencer and request registers
  logic [2:0]     state_r, state_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;          // walk pointer, then found slot, then list-out pointer
  fec_pkg::addr_t req_st_r, req_st_nxt;
  fec_pkg::addr_t req_len_r, req_len_nxt;
  fec_pkg::addr_t es_r, es_nxt;            // start of the hit extent
  logic [AW:0]    ee_r, ee_nxt;            // end of the hit extent, one bit wider
  logic [AW:0]    re_r, re_nxt;            // end of the claimed region
  fec_pkg::addr_t tail_r, tail_nxt;        // length left behind the claim
  fec_pkg::addr_t head_r, head_nxt;        // length left in front of the claim
  logic [1:0]     kind_r, kind_nxt;
  logic [1:0]     status_r, status_nxt;

  // output register
  logic                            out_valid_r, out_valid_nxt;
  logic [fec_pkg::OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic [fec_pkg::OUT_USER_W-1:0]  out_user_r, out_user_nxt;
  logic                            out_last_r, out_last_nxt;

  // single read port onto the table
  fec_pkg::addr_t rd_start, rd_len;
  assign rd_start = start_r[idx_r[IW-1:0]];
  assign rd_len   = len_r[idx_r[IW-1:0]];

  // shared add/subtract unit
  logic [AW:0] alu_a, alu_b, alu_y;
  logic        alu_sub;

  always_comb begin
    alu_a   = {1'b0, req_st_r};
    alu_b   = {1'b0, req_len_r};
    alu_sub = 1'b0;
    unique case (state_r)
      S_SEARCH: begin
        // end of the extent under the walk pointer
        alu_a = {1'b0, rd_start};
        alu_b = {1'b0, rd_len};
      end
      S_TAIL: begin
        alu_a   = ee_r;
        alu_b   = re_r;
        alu_sub = 1'b1;
      end
      S_HEAD: begin
        alu_a   = {1'b0, req_st_r};
        alu_b   = {1'b0, es_r};
        alu_sub = 1'b1;
      end
      default: begin
        // request end in the check state, idle otherwise
      end
    endcase
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  logic in_acc, cfg_acc, out_free;
  logic same_begin, same_end;
  logic last_word;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign out_free   = !out_valid_r || out_tready;
  assign same_begin = (req_st_r == es_r);
  assign same_end   = (alu_y == ee_r);
  assign last_word  = ((idx_r + CW'(1)) == count_r);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    req_st_nxt  = req_st_r;
    req_len_nxt = req_len_r;
    es_nxt      = es_r;
    ee_nxt      = ee_r;
    re_nxt      = re_r;
    tail_nxt    = tail_r;
    head_nxt    = head_r;
    kind_nxt    = kind_r;
    status_nxt  = status_r;

    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_st_nxt  = in_tdata[AW-1:0];
          req_len_nxt = in_tdata[2*AW-1:AW];
          idx_nxt     = '0;
          if (in_tdata[2*AW-1:AW] == '0) begin
            // zero length: table untouched, list still goes out
            status_nxt = fec_pkg::ST_ZERO_LEN;
            state_nxt  = S_EMIT;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (idx_r >= count_r) begin
          // walked off the end without a hit
          status_nxt = fec_pkg::ST_OUTSIDE;
          idx_nxt    = '0;
          state_nxt  = S_EMIT;
        end else if (req_st_r >= rd_start && {1'b0, req_st_r} < alu_y) begin
          es_nxt    = rd_start;
          ee_nxt    = alu_y;
          state_nxt = S_CHECK;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_CHECK: begin
        re_nxt = alu_y;
        if (alu_y > ee_r) begin
          // claim runs past the end of its extent
          status_nxt = fec_pkg::ST_OUTSIDE;
          idx_nxt    = '0;
          state_nxt  = S_EMIT;
        end else if (same_begin && same_end) begin
          kind_nxt  = K_EXACT;
          state_nxt = S_COMMIT;
        end else if (same_begin) begin
          kind_nxt  = K_FRONT;
          state_nxt = S_TAIL;
        end else if (same_end) begin
          kind_nxt  = K_BACK;
          state_nxt = S_HEAD;
        end else if (count_r >= CW'(ME)) begin
          status_nxt = fec_pkg::ST_FULL;
          idx_nxt    = '0;
          state_nxt  = S_EMIT;
        end else begin
          kind_nxt  = K_SPLIT;
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        tail_nxt  = alu_y[AW-1:0];
        state_nxt = (kind_r == K_FRONT) ? S_COMMIT : S_HEAD;
      end
      S_HEAD: begin
        head_nxt  = alu_y[AW-1:0];
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        status_nxt = fec_pkg::ST_OK;
        idx_nxt    = '0;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (count_r == '0) begin
            // empty list: one word carrying no extent
            out_data_nxt = '0;
            out_user_nxt = {status_r, 1'b1};
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            out_data_nxt = {rd_len, rd_start};
            out_user_nxt = {status_r, 1'b0};
            out_last_nxt = last_word;
            idx_nxt      = idx_r + CW'(1);
            if (last_word) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // table update: commit of a claim, or a memory_size write
  always_comb begin
    for (int k = 0; k < ME; k++) begin
      start_nxt[k] = start_r[k];
      len_nxt[k]   = len_r[k];
    end
    count_nxt = count_r;

    if (state_r == S_COMMIT) begin
      case (kind_r)
        K_EXACT: begin
          // close the gap left by the removed extent
          for (int k = 0; k < ME - 1; k++) begin
            if (CW'(k) >= idx_r && (CW'(k) + CW'(1)) < count_r) begin
              start_nxt[k] = start_r[k+1];
              len_nxt[k]   = len_r[k+1];
            end
          end
          count_nxt = count_r - CW'(1);
        end
        K_FRONT: begin
          start_nxt[idx_r[IW-1:0]] = re_r[AW-1:0];
          len_nxt[idx_r[IW-1:0]]   = tail_r;
        end
        K_BACK: begin
          len_nxt[idx_r[IW-1:0]] = head_r;
        end
        default: begin
          // split: open a slot behind the hit extent for the tail part
          for (int k = 1; k < ME; k++) begin
            if (CW'(k) > (idx_r + CW'(1)) && CW'(k) <= count_r) begin
              start_nxt[k] = start_r[k-1];
              len_nxt[k]   = len_r[k-1];
            end else if (CW'(k) == (idx_r + CW'(1))) begin
              start_nxt[k] = re_r[AW-1:0];
              len_nxt[k]   = tail_r;
            end
          end
          len_nxt[idx_r[IW-1:0]] = head_r;
          count_nxt = count_r + CW'(1);
        end
      endcase
    end else if (cfg_acc) begin
      start_nxt[0] = '0;
      len_nxt[0]   = cfg_data;
      count_nxt    = (cfg_data == '0) ? CW'(0) : CW'(1);
    end
  end

  // table storage; entry zero and the count come out of reset as the single extent [0, 65535)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r[0] <= '0;
      len_r[0]   <= '1;
      count_r    <= CW'(1);
    end else begin
      for (int k = 0; k < ME; k++) begin
        start_r[k] <= start_nxt[k];
        len_r[k]   <= len_nxt[k];
      end
      count_r <= count_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and output payload
  always_ff @(posedge clk) begin
    req_st_r   <= req_st_nxt;
    req_len_r  <= req_len_nxt;
    es_r       <= es_nxt;
    ee_r       <= ee_nxt;
    re_r       <= re_nxt;
    tail_r     <= tail_nxt;
    head_r     <= head_nxt;
    kind_r     <= kind_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// File: design/fec_checker.sv
// fec_checker: port-level checks for the free extent claimer
// bound to free_extent_claimer; depends on fec_pkg
`timescale 1ns / 1ps

module fec_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [fec_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [fec_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                           out_tlast
);

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result word changed while stalled");

  // an empty list is a single closing word with no extent
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && out_tdata == '0)
    else $error("empty-list word malformed");

  // a request occupies the sequencer
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one still running");

endmodule

bind free_extent_claimer fec_checker u_fec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: tb/tb_free_extent_claimer.sv
// tb_free_extent_claimer: self-checking bench for the free extent claimer
// drives claim words and memory_size writes, predicts every listed extent, checks the list
// depends on fec_pkg and free_extent_claimer
`timescale 1ns / 1ps

module tb_free_extent_claimer;

  typedef logic [fec_pkg::CNT_W-1:0] count_t;

  // free table as the block should hold it, one copy per user
  typedef struct packed {
    fec_pkg::addr_t [fec_pkg::MAX_EXTENTS-1:0] starts;
    fec_pkg::addr_t [fec_pkg::MAX_EXTENTS-1:0] lens;
    count_t                                    count;
  } extent_table_t;

  // one claim word (start in the low half) and one listed extent word
  typedef struct packed {
    fec_pkg::addr_t length;
    fec_pkg::addr_t start;
  } claim_t;

  typedef struct packed {
    fec_pkg::addr_t start;
    fec_pkg::addr_t length;
    logic           empty;
    logic [1:0]     status;
    logic           last;
  } extent_word_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [fec_pkg::IN_DATA_W-1:0]  in_tdata = '0;  // [15:0] alloc_start, [31:16] alloc_length
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [fec_pkg::OUT_DATA_W-1:0] out_tdata;      // [15:0] extent_start, [31:16] extent_length
  logic [fec_pkg::OUT_USER_W-1:0] out_tuser;      // [0] list_empty, [2:1] status
  logic                           out_tlast;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [fec_pkg::ADDR_W-1:0]     cfg_data = '0;

  free_extent_claimer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // free_map follows accepted words, plan_map runs ahead as claims are queued
  extent_table_t free_map;
  extent_table_t plan_map;
  claim_t        claim_queue[$];
  extent_word_t  expected_extents[$];

  int  n_queued = 0;
  int  n_claims = 0;
  int  n_words = 0;
  int  n_errors = 0;
  int  status_seen[4] = '{0, 0, 0, 0};

  // gap control: per phase each side either idles at random or runs flat out
  bit  tx_busy = 1'b0;
  bit  rx_busy = 1'b0;
  int  tx_wait = 0;
  bit  tx_armed = 1'b0;
  int  rx_wait = 0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;

  // scratch for the clocked blocks
  claim_t       next_claim;
  claim_t       got_claim;
  extent_word_t want;
  logic [1:0]   claim_status;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic extent_table_t fresh_table(input fec_pkg::addr_t size);
    extent_table_t t;
    t = '0;
    // a zero size leaves nothing free
    if (size != 0) begin
      t.lens[0] = size;
      t.count   = count_t'(1);
    end
    return t;
  endfunction

  // claim [st, st+ln) from table t, the four outcomes plus the refusals
  task automatic claim_region(inout extent_table_t t, input fec_pkg::addr_t st,
                              input fec_pkg::addr_t ln, output logic [1:0] code);
    int hit;
    int i;
    int k;
    int es;
    int ee;
    int re;
    hit  = -1;
    code = fec_pkg::ST_OK;
    if (ln == 0) begin
      code = fec_pkg::ST_ZERO_LEN;
    end else begin
      for (i = 0; i < int'(t.count); i++) begin
        es = int'(t.starts[i]);
        ee = es + int'(t.lens[i]);
        if (hit < 0 && int'(st) >= es && int'(st) < ee) hit = i;
      end
      if (hit < 0) begin
        code = fec_pkg::ST_OUTSIDE;
      end else begin
        es = int'(t.starts[hit]);
        ee = es + int'(t.lens[hit]);
        re = int'(st) + int'(ln);
        if (re > ee) begin
          // runs past the end of the extent holding the start
          code = fec_pkg::ST_OUTSIDE;
        end else if (int'(st) == es && re == ee) begin
          // exact fit: close the gap in the table
          for (k = hit; k + 1 < int'(t.count); k++) begin
            t.starts[k] = t.starts[k+1];
            t.lens[k]   = t.lens[k+1];
          end
          t.count = count_t'(int'(t.count) - 1);
          t.starts[t.count] = '0;
          t.lens[t.count]   = '0;
        end else if (int'(st) == es) begin
          t.starts[hit] = fec_pkg::addr_t'(re);
          t.lens[hit]   = fec_pkg::addr_t'(ee - re);
        end else if (re == ee) begin
          t.lens[hit] = fec_pkg::addr_t'(int'(st) - es);
        end else if (int'(t.count) >= fec_pkg::MAX_EXTENTS) begin
          // a split needs a free slot
          code = fec_pkg::ST_FULL;
        end else begin
          for (k = int'(t.count); k > hit + 1; k--) begin
            t.starts[k] = t.starts[k-1];
            t.lens[k]   = t.lens[k-1];
          end
          t.starts[hit+1] = fec_pkg::addr_t'(re);
          t.lens[hit+1]   = fec_pkg::addr_t'(ee - re);
          t.lens[hit]     = fec_pkg::addr_t'(int'(st) - es);
          t.count = count_t'(int'(t.count) + 1);
        end
      end
    end
  endtask

  // queue the words the block must list after a claim
  task automatic list_free_extents(input logic [1:0] code);
    extent_word_t w;
    int k;
    if (free_map.count == 0) begin
      w = '{start: '0, length: '0, empty: 1'b1, status: code, last: 1'b1};
      expected_extents.push_back(w);
    end else begin
      for (k = 0; k < int'(free_map.count); k++) begin
        w.start  = free_map.starts[k];
        w.length = free_map.lens[k];
        w.empty  = 1'b0;
        w.status = code;
        w.last   = (k + 1 == int'(free_map.count));
        expected_extents.push_back(w);
      end
    end
  endtask

  function automatic int draw_gap(input bit busy);
    return busy ? int'($urandom_range(0, 7)) : 0;
  endfunction

  // sampling side: result check, register write and claim prediction at the rising edge
  always @(posedge clk) begin
    in_took  = rst_n && in_tvalid && in_tready;
    out_took = rst_n && out_tvalid && out_tready;
    if (out_took) begin
      n_words++;
      if (expected_extents.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected word start %0d len %0d user %b last %b", $realtime,
                 out_tdata[15:0], out_tdata[31:16], out_tuser, out_tlast);
      end else begin
        want = expected_extents.pop_front();
        if (out_tdata[15:0] !== want.start || out_tdata[31:16] !== want.length ||
            out_tuser[0] !== want.empty || out_tuser[2:1] !== want.status ||
            out_tlast !== want.last) begin
          n_errors++;
          $display("%0t: word mismatch, expected start %0d len %0d empty %0b status %0d last %0b",
                   $realtime, want.start, want.length, want.empty, want.status, want.last);
          $display("%0t:                actual   start %0d len %0d empty %0b status %0d last %0b",
                   $realtime, out_tdata[15:0], out_tdata[31:16], out_tuser[0], out_tuser[2:1],
                   out_tlast);
        end
      end
    end
    if (rst_n && cfg_valid && cfg_ready) free_map = fresh_table(cfg_data);
    if (in_took) begin
      got_claim = in_tdata;
      claim_region(free_map, got_claim.start, got_claim.length, claim_status);
      status_seen[claim_status]++;
      n_claims++;
      list_free_extents(claim_status);
    end
  end

  // claim driver: one gap drawn per word, valid held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_armed = 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (claim_queue.size() != 0 && !tx_armed) begin
        tx_wait  = draw_gap(tx_busy);
        tx_armed = 1'b1;
      end
      if (tx_armed && tx_wait == 0) begin
        next_claim = claim_queue.pop_front();
        in_tdata  <= next_claim;
        in_tvalid <= 1'b1;
        tx_armed = 1'b0;
      end else begin
        in_tvalid <= 1'b0;
        if (tx_armed) tx_wait--;
      end
    end
  end

  // result sink: after each word taken, stall for a drawn number of cycles
  always @(negedge clk) begin
    if (out_took) rx_wait = draw_gap(rx_busy);
    if (rx_wait > 0) begin
      out_tready <= 1'b0;
      rx_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // queue one claim and advance the planning copy so later picks see its effect
  task automatic push_claim(input int st, input int ln);
    claim_t     c;
    logic [1:0] code;
    c.start  = fec_pkg::addr_t'(st);
    c.length = fec_pkg::addr_t'(ln);
    claim_region(plan_map, c.start, c.length, code);
    claim_queue.push_back(c);
    n_queued++;
  endtask

  function automatic int short_len(input int lim);
    if (lim <= 16 || $urandom_range(0, 1)) return $urandom_range(1, lim);
    return $urandom_range(1, 16);
  endfunction

  // mostly well-formed claims on a live extent, the rest zero length or noise
  task automatic random_claim;
    int pick;
    int j;
    int es;
    int el;
    int st;
    int ln;
    pick = $urandom_range(0, 9);
    if (pick >= 2 && plan_map.count != 0) begin
      j  = $urandom_range(0, int'(plan_map.count) - 1);
      es = int'(plan_map.starts[j]);
      el = int'(plan_map.lens[j]);
      case ($urandom_range(0, 4))
        0: begin
          st = es;
          ln = el;
        end
        1: begin
          st = es;
          ln = short_len(el);
        end
        2: begin
          ln = short_len(el);
          st = es + el - ln;
        end
        3: begin
          if (el >= 3) begin
            st = es + $urandom_range(1, el - 2);
            ln = short_len(es + el - 1 - st);
          end else begin
            st = es;
            ln = el;
          end
        end
        default: begin
          // overruns its extent by one unit
          st = es + $urandom_range(0, el - 1);
          ln = es + el - st + 1;
          if (ln > 65535) ln = 65535;
        end
      endcase
    end else if (pick == 1) begin
      st = $urandom_range(0, 65535);
      ln = 0;
    end else begin
      st = $urandom_range(0, 65535);
      ln = $urandom_range(0, 1) ? $urandom_range(1, 65535) : $urandom_range(1, 16);
    end
    push_claim(st, ln);
  endtask

  // sender holds off until every queued claim is taken and every word is back
  task automatic wait_drained;
    while (claim_queue.size() != 0 || n_claims != n_queued || expected_extents.size() != 0)
      @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_size(input fec_pkg::addr_t size);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    plan_map = fresh_table(size);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase(input fec_pkg::addr_t size, input int n);
    int i;
    write_size(size);
    tx_busy = 1'($urandom_range(0, 1));
    rx_busy = 1'($urandom_range(0, 1));
    for (i = 0; i < n; i++) random_claim();
  endtask

  initial begin
    int i;
    free_map = fresh_table(16'hFFFF);
    plan_map = fresh_table(16'hFFFF);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, out of reset with [0, 65535) free
    tx_busy = 1'b1;
    rx_busy = 1'b1;
    push_claim(0, 0);             // zero length
    push_claim(0, 100);           // trim front
    push_claim(65535, 1);         // top unit, not free
    push_claim(200, 65535);       // longest length runs past the end
    push_claim(65000, 535);       // trim back
    push_claim(1000, 50);         // split
    push_claim(1000, 50);         // start already claimed
    push_claim(100, 900);         // exact fit removes an extent
    for (i = 0; i < 15; i++) push_claim(2000 + i * 100, 10);  // splits up to a full table
    push_claim(5000, 10);         // split refused, table full

    // single unit space: emptied list, then a claim on nothing
    write_size(16'd1);
    tx_busy = 1'b0;
    push_claim(0, 1);
    push_claim(0, 1);

    // zero size: list is empty from the start
    write_size(16'd0);
    rx_busy = 1'b0;
    push_claim(0, 0);
    push_claim(7, 3);

    // small space, receiver stalling only
    write_size(16'd40);
    tx_busy = 1'b0;
    rx_busy = 1'b1;
    for (i = 0; i < 30; i++) random_claim();

    // full space, sender gaps; pause midway until the list-out drains
    write_size(16'hFFFF);
    tx_busy = 1'b1;
    rx_busy = 1'b0;
    for (i = 0; i < 18; i++) random_claim();
    wait_drained();
    tx_busy = 1'b0;
    for (i = 0; i < 18; i++) random_claim();

    random_phase(fec_pkg::addr_t'($urandom_range(2, 65534)), 30);
    random_phase(16'd3, 8);

    wait_drained();
    $display("covered %0d claims, %0d extent words: ok %0d, outside %0d, full %0d, zero %0d",
             n_claims, n_words, status_seen[fec_pkg::ST_OK], status_seen[fec_pkg::ST_OUTSIDE],
             status_seen[fec_pkg::ST_FULL], status_seen[fec_pkg::ST_ZERO_LEN]);
    $display("memory sizes 0, 1, 3, 40, 65535 and one random, with both sides idling");
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // generous bound on the whole run
  initial begin
    #2000000;
    $display("%0t: timeout, %0d words still expected", $realtime, expected_extents.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
